// ===== src/lfcr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfcr_pkg
// Shared types, constants and the CRC-16 byte update for the framed receiver.
// ----------------------------------------------------------------------------
package lfcr_pkg;

   localparam int MAX_PAYLOAD = 32;

   localparam int BYTE_W  = 8;
   localparam int CFG_W   = 6;
   localparam int KIND_W  = 3;

   localparam logic [CFG_W-1:0]  MAX_LENGTH_RESET = 6'd34;
   localparam logic [BYTE_W-1:0] START_BYTE       = 8'h02;
   localparam logic [BYTE_W-1:0] END_BYTE         = 8'h03;
   localparam logic [15:0]       CRC_POLY         = 16'h1021;
   localparam logic [15:0]       CRC_INIT         = 16'hFFFF;

   localparam logic [KIND_W-1:0] EV_BYTE    = 3'd0;
   localparam logic [KIND_W-1:0] EV_EMPTY   = 3'd1;
   localparam logic [KIND_W-1:0] EV_LEN_ERR = 3'd2;
   localparam logic [KIND_W-1:0] EV_CRC_ERR = 3'd3;
   localparam logic [KIND_W-1:0] EV_ETX_ERR = 3'd4;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_LEN,
      ST_DATA,
      ST_CRCH,
      ST_CRCL,
      ST_ETX,
      ST_BURST
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic              load_len;
      logic              store_data;
      logic              load_crch;
      logic              post_err;
      logic [KIND_W-1:0] err_kind;
      logic              post_empty;
      logic              start_burst;
      logic              burst;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_start;
      logic len_bad;
      logic len_two;
      logic data_last;
      logic crc_ok;
      logic is_etx;
      logic empty_frame;
      logic out_free;
      logic burst_done;
   } status_type;

   // CRC-16/IBM-3740, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_i,
                                              input logic [BYTE_W-1:0] b);
      logic [15:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== src/lfcr_if.sv =====
// ----------------------------------------------------------------------------
// lfcr_if
// Valid/ready channels of the framed receiver: bytes in, events out, csr write.
// ----------------------------------------------------------------------------
interface lfcr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfcr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_kind;
   logic [7:0] payload_byte;
   logic       last_item;

   modport source (output valid, output event_kind, output payload_byte,
                   output last_item, input ready);
   modport sink   (input valid, input event_kind, input payload_byte,
                   input last_item, output ready);
endinterface

interface lfcr_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface

// ===== src/length_framed_crc16_receiver_top.sv =====
// ----------------------------------------------------------------------------
// length_framed_crc16_receiver_top
// STX / length / payload / CRC-16 / ETX frame receiver with payload burst out.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one received byte per item. rsp_if carries events: payload
//   bytes of a good frame (last one marked), an empty-frame item, or a single
//   length, CRC or ETX error item. csr_if writes max_length; it is always ready.
//   The user writes it only while the block is idle; this is not enforced.
// Throughput:
//   In the header, payload and CRC phases a byte is taken every cycle unless
//   it must wait for the output slot; the CRC-16 update of one byte is
//   combinational. An error or empty frame item is valid the cycle after the
//   byte that causes it. After a good ETX the payload store is read out
//   through its registered port into the pending stage and the output
//   register, one item per cycle while rsp_if.ready is high; req_if is held
//   off until the burst is done.
// Reset:
//   Synchronous, active high. Returns to the STX hunt, max_length becomes 34.
//   The payload store is not cleared; it is always written before it is read.
// Stall:
//   One output register holds a waiting item. Bytes that cannot raise an
//   event are still taken; a byte that may raise one waits for the slot, and
//   the burst pauses while rsp_if.ready is low.
// ----------------------------------------------------------------------------
module length_framed_crc16_receiver_top #(
   parameter int MAX_PAYLOAD = lfcr_pkg::MAX_PAYLOAD
) (
   input  logic   clock,
   input  logic   reset,
   lfcr_req_if.sink   req_if,
   lfcr_rsp_if.source rsp_if,
   lfcr_csr_if.sink   csr_if
);
   import lfcr_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;

   lfcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfcr_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_if.rx_byte),
      .csr_write (csr_if.valid),
      .csr_wdata (csr_if.wdata),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_kind  (rsp_if.event_kind),
      .rsp_byte  (rsp_if.payload_byte),
      .rsp_last  (rsp_if.last_item),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// ===== src/lfcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfcr_ctrl
// Frame state machine: walks STX, length, payload, CRC, ETX and the burst.
// ----------------------------------------------------------------------------
module lfcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lfcr_pkg::status_type status,
   output lfcr_pkg::cmd_type    cmd
);
   import lfcr_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      // bytes that may post an event need the output slot
      unique case (state_ff)
         ST_HUNT, ST_DATA, ST_CRCH: req_ready = 1'b1;
         ST_LEN, ST_CRCL, ST_ETX:   req_ready = status.out_free;
         default:                   req_ready = 1'b0;
      endcase
      take = req_valid && req_ready;

      unique case (state_ff)
         ST_HUNT: begin
            if (take && status.is_start) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            if (take) begin
               if (status.len_bad) begin
                  cmd.post_err = 1'b1;
                  cmd.err_kind = EV_LEN_ERR;
                  state_in     = ST_HUNT;
               end else begin
                  cmd.load_len = 1'b1;
                  state_in     = status.len_two ? ST_CRCH : ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (take) begin
               cmd.store_data = 1'b1;
               if (status.data_last) begin
                  state_in = ST_CRCH;
               end
            end
         end
         ST_CRCH: begin
            if (take) begin
               cmd.load_crch = 1'b1;
               state_in      = ST_CRCL;
            end
         end
         ST_CRCL: begin
            if (take) begin
               if (!status.crc_ok) begin
                  cmd.post_err = 1'b1;
                  cmd.err_kind = EV_CRC_ERR;
                  state_in     = ST_HUNT;
               end else begin
                  state_in = ST_ETX;
               end
            end
         end
         ST_ETX: begin
            if (take) begin
               if (!status.is_etx) begin
                  cmd.post_err = 1'b1;
                  cmd.err_kind = EV_ETX_ERR;
                  state_in     = ST_HUNT;
               end else if (status.empty_frame) begin
                  cmd.post_empty = 1'b1;
                  state_in       = ST_HUNT;
               end else begin
                  cmd.start_burst = 1'b1;
                  state_in        = ST_BURST;
               end
            end
         end
         ST_BURST: begin
            cmd.burst = 1'b1;
            if (status.burst_done) begin
               state_in = ST_HUNT;
            end
         end
         default: state_in = ST_HUNT;
      endcase
   end

   // a good ETX with payload always leads into the burst
   a_etx_to_burst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ETX && take && status.is_etx && !status.empty_frame)
      |=> (state_ff == ST_BURST))
      else $error("good ETX did not start the payload burst");

endmodule

// ===== src/lfcr_datapath.sv =====
// ----------------------------------------------------------------------------
// lfcr_datapath
// Length/CRC registers, payload store, burst read pipe and output register.
// ----------------------------------------------------------------------------
module lfcr_datapath #(
   parameter int MAX_PAYLOAD = lfcr_pkg::MAX_PAYLOAD
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [lfcr_pkg::BYTE_W-1:0]    rx_byte,
   input  logic                           csr_write,
   input  logic [lfcr_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [lfcr_pkg::KIND_W-1:0]    rsp_kind,
   output logic [lfcr_pkg::BYTE_W-1:0]    rsp_byte,
   output logic                           rsp_last,
   input  lfcr_pkg::cmd_type              cmd,
   output lfcr_pkg::status_type           status
);
   import lfcr_pkg::*;

   localparam int LEN_W = $clog2(MAX_PAYLOAD + 3);
   localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [BYTE_W-1:0] LEN_LIMIT = BYTE_W'(MAX_PAYLOAD + 2);

   logic [CFG_W-1:0]  max_length_ff;
   logic [LEN_W-1:0]  frame_len_ff;
   logic [LEN_W-1:0]  byte_cnt_ff;
   logic [LEN_W-1:0]  byte_cnt_in;
   logic [15:0]       crc_ff;
   logic [7:0]        crch_ff;
   logic [LEN_W-1:0]  n_len;
   logic [LEN_W:0]    done_sum;

   logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
   logic [LEN_W-1:0]  rd_cnt_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              pend_ff;
   logic              pend_last_ff;
   logic              issue;
   logic              move;

   logic              out_valid_ff;
   logic [KIND_W-1:0] out_kind_ff;
   logic [BYTE_W-1:0] out_byte_ff;
   logic              out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else if (csr_write) begin
         max_length_ff <= csr_wdata;
      end
   end

   assign byte_cnt_in = byte_cnt_ff + LEN_W'(1);
   assign done_sum    = (LEN_W+1)'(byte_cnt_in) + (LEN_W+1)'(2);
   assign n_len       = frame_len_ff - LEN_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_len_ff <= '0;
         byte_cnt_ff  <= '0;
         crc_ff       <= CRC_INIT;
         crch_ff      <= '0;
      end else begin
         if (cmd.load_len) begin
            frame_len_ff <= rx_byte[LEN_W-1:0];
            byte_cnt_ff  <= '0;
            crc_ff       <= crc16_byte(CRC_INIT, rx_byte);
         end else if (cmd.store_data) begin
            byte_cnt_ff <= byte_cnt_in;
            crc_ff      <= crc16_byte(crc_ff, rx_byte);
         end
         if (cmd.load_crch) begin
            crch_ff <= rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_data) begin
         mem[byte_cnt_ff[AW-1:0]] <= rx_byte;
      end
   end

   // burst: memory read -> pending stage -> output register
   assign move  = pend_ff && (!out_valid_ff || rsp_ready);
   assign issue = cmd.burst && (rd_cnt_ff != n_len) && (!pend_ff || move);

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff   <= mem[rd_cnt_ff[AW-1:0]];
         pend_last_ff <= (rd_cnt_ff + LEN_W'(1)) == n_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         if (cmd.start_burst) begin
            rd_cnt_ff <= '0;
         end else if (issue) begin
            rd_cnt_ff <= rd_cnt_ff + LEN_W'(1);
         end
         if (issue) begin
            pend_ff <= 1'b1;
         end else if (move) begin
            pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.post_err || cmd.post_empty || move) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post_err) begin
         out_kind_ff <= cmd.err_kind;
         out_byte_ff <= '0;
         out_last_ff <= 1'b1;
      end else if (cmd.post_empty) begin
         out_kind_ff <= EV_EMPTY;
         out_byte_ff <= '0;
         out_last_ff <= 1'b1;
      end else if (move) begin
         out_kind_ff <= EV_BYTE;
         out_byte_ff <= rd_data_ff;
         out_last_ff <= pend_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_byte  = out_byte_ff;
   assign rsp_last  = out_last_ff;

   always_comb begin
      status.is_start    = rx_byte == START_BYTE;
      status.len_bad     = (rx_byte < BYTE_W'(2)) ||
                           (rx_byte > BYTE_W'(max_length_ff)) ||
                           (rx_byte > LEN_LIMIT);
      status.len_two     = rx_byte == BYTE_W'(2);
      status.data_last   = done_sum >= (LEN_W+1)'(frame_len_ff);
      status.crc_ok      = {crch_ff, rx_byte} == crc_ff;
      status.is_etx      = rx_byte == END_BYTE;
      status.empty_frame = frame_len_ff == LEN_W'(2);
      status.out_free    = !out_valid_ff || rsp_ready;
      status.burst_done  = (rd_cnt_ff == n_len) && !pend_ff;
   end

   a_post_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.post_err || cmd.post_empty) |-> (!out_valid_ff || rsp_ready) && !pend_ff)
      else $error("event posted over an undelivered item");

   a_store_in_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.store_data |-> (byte_cnt_ff < n_len))
      else $error("payload write beyond frame length");

   a_read_in_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.burst |-> (rd_cnt_ff <= n_len) && (n_len != '0))
      else $error("burst read counter out of range");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the STX / length / CRC-16 / ETX frame receiver.
// A queue of bytes feeds a valid/ready driver; a clocked monitor predicts
// each accepted byte's events and checks every event item in order. Phases
// change max_length while idle: reset value, 63, 2, 1, 0, a random setting
// with a long sink hold-off, and back to 34.
// ----------------------------------------------------------------------------
module tb_top;
   import lfcr_pkg::*;

   localparam int TIMEOUT_CYCLES = 500000;
   localparam int DRAIN_CYCLES   = 4000;
   localparam int IDLE_CYCLES    = 16;
   localparam int LONG_HOLD      = 200;
   localparam int PAY_AW         = $clog2(MAX_PAYLOAD);

   typedef enum {GOOD_FRAME, BAD_CRC, BAD_ETX, ETX_IS_STX} frame_fault_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [7:0]        data;
      logic              last;
   } rx_event_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lfcr_req_if req_ch ();
   lfcr_rsp_if rsp_ch ();
   lfcr_csr_if csr_ch ();

   length_framed_crc16_receiver_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // stimulus and bookkeeping
   logic [7:0]   tx_bytes [$];
   rx_event_type awaited_events [$];
   int           bytes_queued  = 0;
   int           bytes_taken   = 0;
   int           fail_count    = 0;
   int           cycle_count   = 0;
   int           hold_requests = 0;
   int           hold_served   = 0;
   logic         req_took      = 1'b0;
   logic         rsp_took      = 1'b0;

   // receiver shadow state
   logic [CFG_W-1:0] shadow_max;
   state_type        frame_phase;
   logic [5:0]       frame_len;
   logic [5:0]       byte_cnt;
   logic [15:0]      run_crc;
   logic [7:0]       crc_hi;
   logic [7:0]       frame_payload [MAX_PAYLOAD];

   // bitwise CRC-16/IBM-3740 update, MSB first
   function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic void fail_frame(logic [KIND_W-1:0] kind);
      awaited_events.push_back('{kind, 8'h00, 1'b1});
      frame_phase = ST_HUNT;
      byte_cnt    = '0;
   endfunction

   function automatic void take_rx_byte(logic [7:0] b);
      int n;
      unique case (frame_phase)
         ST_HUNT: begin
            if (b == START_BYTE) begin
               byte_cnt    = '0;
               run_crc     = CRC_INIT;
               frame_phase = ST_LEN;
            end
         end
         ST_LEN: begin
            if (b < 2 || b > shadow_max || b > MAX_PAYLOAD + 2) begin
               fail_frame(EV_LEN_ERR);
            end else begin
               frame_len   = b[5:0];
               run_crc     = crc16_next(CRC_INIT, b);
               byte_cnt    = '0;
               frame_phase = (frame_len == 2) ? ST_CRCH : ST_DATA;
            end
         end
         ST_DATA: begin
            if (byte_cnt < MAX_PAYLOAD) frame_payload[byte_cnt[PAY_AW-1:0]] = b;
            run_crc  = crc16_next(run_crc, b);
            byte_cnt = byte_cnt + 6'd1;
            if (int'(byte_cnt) + 2 >= int'(frame_len)) frame_phase = ST_CRCH;
         end
         ST_CRCH: begin
            crc_hi      = b;
            frame_phase = ST_CRCL;
         end
         ST_CRCL: begin
            if ({crc_hi, b} != run_crc) fail_frame(EV_CRC_ERR);
            else frame_phase = ST_ETX;
         end
         ST_ETX: begin
            if (b != END_BYTE) begin
               fail_frame(EV_ETX_ERR);
            end else begin
               frame_phase = ST_HUNT;
               byte_cnt    = '0;
               n = (frame_len >= 2) ? int'(frame_len) - 2 : 0;
               if (n > MAX_PAYLOAD) n = MAX_PAYLOAD;
               if (n == 0) begin
                  awaited_events.push_back('{EV_EMPTY, 8'h00, 1'b1});
               end else begin
                  for (int i = 0; i < n; i++) begin
                     awaited_events.push_back('{EV_BYTE, frame_payload[i], i == n - 1});
                  end
               end
            end
         end
         default: begin
            frame_phase = ST_HUNT;
            byte_cnt    = '0;
         end
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      fail_count++;
      if (fail_count <= 40) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   // random wait per item, with occasional runs of back-to-back items
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 32);
         return 0;
      end
      return $urandom_range(0, 5);
   endfunction

   // ---------------------------------------------------------------- driver
   int src_wait = 0;
   int src_calm = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= 8'h00;
      end else if (!req_ch.valid || req_took) begin
         if (src_wait > 0) begin
            src_wait--;
            req_ch.valid <= 1'b0;
         end else if (tx_bytes.size() != 0) begin
            req_ch.rx_byte <= tx_bytes.pop_front();
            req_ch.valid   <= 1'b1;
            src_wait = draw_wait(src_calm);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------ sink
   int sink_wait = 0;
   int sink_calm = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_took) sink_wait = draw_wait(sink_calm);
         if (hold_served != hold_requests) begin
            sink_wait   = LONG_HOLD;
            hold_served = hold_requests;
         end
         if (sink_wait > 0) begin
            sink_wait--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------------- monitor
   always @(posedge clock) begin
      rx_event_type got, want;
      req_took <= !reset && req_ch.valid && req_ch.ready;
      rsp_took <= !reset && rsp_ch.valid && rsp_ch.ready;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) shadow_max = csr_ch.wdata;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.event_kind, rsp_ch.payload_byte, rsp_ch.last_item};
            if (awaited_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event kind %0d byte %02h last %b",
                                         got.kind, got.data, got.last));
            end else begin
               want = awaited_events.pop_front();
               if (got.kind !== want.kind || got.data !== want.data ||
                   got.last !== want.last) begin
                  report_mismatch($sformatf({"event kind %0d byte %02h last %b, ",
                                             "expected %0d %02h %b"},
                                            got.kind, got.data, got.last,
                                            want.kind, want.data, want.last));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            bytes_taken++;
            take_rx_byte(req_ch.rx_byte);
         end
      end
      cycle_count++;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("** length_framed_crc16_receiver_top: FAILED **");
         $finish;
      end
   end

   // -------------------------------------------------------------- stimulus
   task automatic push_byte(logic [7:0] b);
      tx_bytes.push_back(b);
      bytes_queued++;
   endtask

   // fill < 0 gives random payload
   task automatic push_frame(int plen, frame_fault_type fault, int fill = -1);
      logic [7:0]  len_byte, b, etx;
      logic [15:0] crc;
      len_byte = 8'(plen + 2);
      crc      = crc16_next(CRC_INIT, len_byte);
      push_byte(START_BYTE);
      push_byte(len_byte);
      for (int i = 0; i < plen; i++) begin
         b   = (fill < 0) ? 8'($urandom) : 8'(fill);
         crc = crc16_next(crc, b);
         push_byte(b);
      end
      if (fault == BAD_CRC) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      push_byte(crc[15:8]);
      push_byte(crc[7:0]);
      case (fault)
         BAD_ETX: begin
            etx = 8'($urandom);
            if (etx == END_BYTE) etx = ~etx;
         end
         ETX_IS_STX: etx = START_BYTE;
         default:    etx = END_BYTE;
      endcase
      push_byte(etx);
   endtask

   task automatic push_random_frames(int budget);
      int first, pick, plen;
      first = bytes_queued;
      while (bytes_queued - first < budget) begin
         pick = $urandom_range(0, 99);
         plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_PAYLOAD)
                                            : $urandom_range(0, 6);
         if (pick < 55) begin
            push_frame(plen, GOOD_FRAME);
         end else if (pick < 65) begin
            push_frame(plen, BAD_CRC);
         end else if (pick < 72) begin
            push_frame(plen, BAD_ETX);
         end else if (pick < 76) begin
            push_frame(plen, ETX_IS_STX);
         end else if (pick < 88) begin
            push_byte(START_BYTE);
            push_byte(pick[0] ? 8'($urandom_range(0, 1))
                              : 8'($urandom_range(MAX_PAYLOAD + 3, 255)));
         end else begin
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
         end
      end
   endtask

   task automatic write_max_length(logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_ch.wdata <= value;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // all bytes taken, awaited events drained or reported missing, then idle
   task automatic settle();
      int k;
      wait (bytes_taken == bytes_queued);
      for (k = 0; k < DRAIN_CYCLES && awaited_events.size() != 0; k++) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
      if (awaited_events.size() != 0) begin
         report_mismatch($sformatf("%0d events never arrived", awaited_events.size()));
         awaited_events.delete();
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      rsp_ch.ready   = 1'b0;
      csr_ch.valid   = 1'b0;
      csr_ch.wdata   = '0;
      shadow_max     = MAX_LENGTH_RESET;
      frame_phase    = ST_HUNT;
      frame_len      = '0;
      byte_cnt       = '0;
      run_crc        = CRC_INIT;
      crc_hi         = 8'h00;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, max_length at reset value
      push_frame(0, GOOD_FRAME);
      push_frame(1, GOOD_FRAME, 0);
      push_frame(MAX_PAYLOAD, GOOD_FRAME, 255);
      push_frame(3, GOOD_FRAME, int'(START_BYTE));
      push_frame(3, BAD_CRC);
      push_frame(2, BAD_ETX);
      // error byte is a start byte: hunt must resume on the byte after it
      push_frame(1, ETX_IS_STX);
      push_byte(8'h03);
      push_byte(8'hAA);
      push_frame(2, GOOD_FRAME);
      push_byte(START_BYTE); push_byte(8'h00);
      push_byte(START_BYTE); push_byte(8'h01);
      push_byte(START_BYTE); push_byte(8'd35);
      push_byte(START_BYTE); push_byte(8'h40);
      push_byte(START_BYTE); push_byte(8'hFF);
      settle();

      // widest register: store bound takes over
      write_max_length(6'd63);
      push_frame(MAX_PAYLOAD, GOOD_FRAME);
      push_byte(START_BYTE); push_byte(8'd35);
      push_byte(START_BYTE); push_byte(8'd63);
      push_random_frames(6);
      settle();

      write_max_length(6'd2);
      push_frame(0, GOOD_FRAME);
      push_frame(1, GOOD_FRAME);
      push_random_frames(4);
      settle();

      // register below 2 rejects everything
      write_max_length(6'd1);
      push_frame(0, GOOD_FRAME);
      push_random_frames(4);
      settle();
      write_max_length(6'd0);
      push_frame(0, GOOD_FRAME);
      push_frame(4, GOOD_FRAME);
      settle();

      // sink stalls for a long stretch while bytes keep coming
      write_max_length(6'($urandom_range(10, 33)));
      hold_requests++;
      push_frame(8, GOOD_FRAME);
      push_random_frames(10);
      settle();

      write_max_length(MAX_LENGTH_RESET);
      push_random_frames(8);
      settle();

      if (fail_count == 0) begin
         $display("** length_framed_crc16_receiver_top: PASSED **");
      end else begin
         $display("** length_framed_crc16_receiver_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== length_framed_crc16_receiver_top.f =====
src/lfcr_pkg.sv
src/lfcr_if.sv
src/lfcr_ctrl.sv
src/lfcr_datapath.sv
src/length_framed_crc16_receiver_top.sv
sim/tb_top.sv
